@@ hdl/ost_pkg.sv @@
// ----------------------------------------------------------------------------
// ost_pkg: shared types and constants for the ordered set table
// Sizes, request codes, cell control struct and key width helpers.
// ----------------------------------------------------------------------------
package ost_pkg;

    localparam int CAPACITY  = 32;
    localparam int KEY_BITS  = 32;
    localparam int PORT_KEY  = 32;   // key width on the stream words
    localparam int RANK_BITS = 5;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int RC_W      = (CNT_W > RANK_BITS) ? CNT_W : RANK_BITS;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_ERASE    = 2'd1,
        REQ_CONTAINS = 2'd2,
        REQ_GET      = 2'd3
    } req_kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        logic cmp;   // register compare flags against key
        logic ins;   // insert key at the lower-bound position
        logic era;   // remove the matching entry, close the gap
        key_t key;
    } cell_ctl_t;

    // what a cell hands to its upper neighbour
    typedef struct packed {
        logic lt;
        key_t key;
    } cell_link_t;

    // result word, ok in the lowest bit
    typedef struct packed {
        cnt_t                entry_count;
        logic [PORT_KEY-1:0] key_out;
        logic                ok;
    } rsp_t;

    function automatic key_t to_key(input logic [PORT_KEY-1:0] k);
        key_t r;
        r = '0;
        for (int i = 0; i < KEY_BITS && i < PORT_KEY; i++) r[i] = k[i];
        return r;
    endfunction

    function automatic logic [PORT_KEY-1:0] from_key(input key_t k);
        logic [PORT_KEY-1:0] r;
        r = '0;
        for (int i = 0; i < KEY_BITS && i < PORT_KEY; i++) r[i] = k[i];
        return r;
    endfunction

endpackage

@@ hdl/ost_cell.sv @@
// ----------------------------------------------------------------------------
// ost_cell: one slot of the sorted key chain
// Holds one key, registers its compare flags, shifts up or down on commit.
// ----------------------------------------------------------------------------
module ost_cell
    import ost_pkg::*;
(
    input  logic       aclk,
    input  cell_ctl_t  ctl,
    input  logic       occupied,
    input  cell_link_t prev_link,   // from the cell below (lower rank)
    input  key_t       next_key,    // from the cell above (higher rank)
    output cell_link_t link,
    output logic       eq_q
);

    key_t key_reg,   key_next;
    logic lt_reg,    lt_next;
    logic eq_reg,    eq_next;

    always_comb begin
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        key_next = key_reg;
        if (ctl.cmp) begin
            lt_next = occupied && (key_reg < ctl.key);
            eq_next = occupied && (key_reg == ctl.key);
        end
        if (ctl.ins && !lt_reg) begin
            key_next = prev_link.lt ? ctl.key : prev_link.key;
        end else if (ctl.era && !lt_reg) begin
            key_next = next_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign link.lt  = lt_reg;
    assign link.key = key_reg;
    assign eq_q     = eq_reg;

endmodule

@@ hdl/ordered_set_table.sv @@
// ----------------------------------------------------------------------------
// ordered_set_table: bounded set of distinct keys held in ascending order
// A row of cells keeps the keys sorted; requests insert, erase, test or
// read by rank, each giving one result word with the entry count.
// ----------------------------------------------------------------------------
// Usage
//   Input word : s_tuser = request kind (0 insert, 1 erase, 2 contains,
//                3 get); s_tdata = key and rank.
//   Result word: m_tdata = ok, key read by a get, entry count after the
//                request.
//   Sequence   : every cell compares its key on the accept edge; the request
//                then waits in the busy state until the output register is
//                free, and on the commit edge the cells shift in one step
//                and the result is registered into the output register.
//   Flow       : a new word is taken only once the previous request has
//                committed; s_tready is low while a request is pending.
//   Reset      : aresetn low on a rising edge empties the set and drops any
//                pending result. The key cells are not cleared: only cells
//                below the entry count are ever read.
//   Stall      : a result waits in the output register while m_tready is
//                low. One further word is taken meanwhile; its commit waits
//                until the output register frees up.
// ----------------------------------------------------------------------------
module ordered_set_table
    import ost_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key[31:0], rank_index[36:32], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // ok[0], key_out[32:1], entry_count[38:33]
);

    // request held for the commit cycle
    state_t             state_reg, state_next;
    req_kind_t          kind_reg;
    key_t               key_reg;
    logic [RANK_BITS-1:0] rank_reg;
    cnt_t               count_reg, count_next;

    // output register
    logic m_valid_reg, m_valid_next;
    rsp_t rsp_reg,     rsp_next;

    logic       accept, commit, found, ins_ok, era_ok, rank_ok;
    key_t       in_key, get_key;
    cell_ctl_t  ctl;
    cell_link_t links [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;

    assign in_key = to_key(s_tdata[PORT_KEY-1:0]);
    assign accept = s_tvalid && s_tready;

    // ---- sequencer: next state ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_BUSY;
            ST_BUSY: if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_BUSY: commit   = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    // ---- decisions from the registered compare flags ----
    assign found   = |eq_vec;
    assign ins_ok  = (kind_reg == REQ_INSERT) && !found && (count_reg < cnt_t'(CAPACITY));
    assign era_ok  = (kind_reg == REQ_ERASE) && found;
    assign rank_ok = RC_W'(rank_reg) < RC_W'(count_reg);

    always_comb begin
        get_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (RC_W'(i) == RC_W'(rank_reg)) get_key = links[i].key;
        end
    end

    // broadcast to the cells; compare uses the incoming key
    always_comb begin
        ctl.cmp = accept;
        ctl.ins = commit && ins_ok;
        ctl.era = commit && era_ok;
        ctl.key = (state_reg == ST_IDLE) ? in_key : key_reg;
    end

    // ---- the cell row ----
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        cell_link_t prev_l;
        key_t       nxt_k;
        logic       occ;

        assign occ = cnt_t'(g) < count_reg;

        if (g == 0) begin : g_first
            assign prev_l = '{lt: 1'b1, key: '0};   // bottom cell takes the new key
        end else begin : g_mid
            assign prev_l = links[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign nxt_k = '0;
        end else begin : g_up
            assign nxt_k = links[g+1].key;
        end

        ost_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .occupied  (occ),
            .prev_link (prev_l),
            .next_key  (nxt_k),
            .link      (links[g]),
            .eq_q      (eq_vec[g])
        );
    end

    // ---- count and result ----
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        rsp_next     = rsp_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if (commit) begin
            if (ins_ok) count_next = count_reg + cnt_t'(1);
            if (era_ok) count_next = count_reg - cnt_t'(1);
            m_valid_next         = 1'b1;
            rsp_next.entry_count = count_next;
            rsp_next.key_out     = '0;
            unique case (kind_reg)
                REQ_INSERT:   rsp_next.ok = ins_ok;
                REQ_ERASE:    rsp_next.ok = era_ok;
                REQ_CONTAINS: rsp_next.ok = found;
                REQ_GET: begin
                    rsp_next.ok = rank_ok;
                    if (rank_ok) rsp_next.key_out = from_key(get_key);
                end
                default:      rsp_next.ok = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
        if (accept) begin
            kind_reg <= req_kind_t'(s_tuser);
            key_reg  <= in_key;
            rank_reg <= s_tdata[PORT_KEY+RANK_BITS-1:PORT_KEY];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 40'(rsp_reg);

    // ---- checks ----
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(CAPACITY))
        else $error("entry count beyond capacity");

    a_cnt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> $stable(count_reg))
        else $error("entry count moved without a commit");

    a_ins_step: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && ins_ok |=> count_reg == $past(count_reg) + cnt_t'(1))
        else $error("successful insert did not add one entry");

    a_rsp_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid && rsp_reg.entry_count == count_reg)
        else $error("result count differs from held count");

endmodule
